>>> rtl/core/tie_pkg.sv
// Package for the tetrahedral isosurface extractor.
// Holds widths, request codes, the vertex word type and the cut order table.
// Depends on nothing.
package tie_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int ADDR_BITS    = $clog2(VERTEX_DEPTH);
    localparam int SLOT_BITS    = 12;
    localparam int COORD_BITS   = 16;
    localparam int DENS_BITS    = 16;
    localparam int CNT_BITS     = 24;
    // Dividend 2*mag*num + den, and divider remainder widths.
    localparam int NUM_BITS     = COORD_BITS + DENS_BITS + 2;
    localparam int REM_BITS     = DENS_BITS + 2;
    localparam int STEP_BITS    = $clog2(COORD_BITS);

    typedef logic [1:0] t_req;
    localparam t_req REQ_LOAD    = 2'd0;
    localparam t_req REQ_TETRA   = 2'd1;
    localparam t_req REQ_RESTART = 2'd2;

    // One vertex table entry.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [DENS_BITS-1:0]  d;
    } t_vtx;

    // Where the level lies among the sorted corner densities.
    typedef enum logic [1:0] {
        MODE_LOW,
        MODE_QUAD,
        MODE_HIGH
    } t_mode;

    // One cut edge: sorted corner ranks of its ends and the triangle offset.
    typedef struct packed {
        logic [1:0] lo;
        logic [1:0] hi;
        logic       tri_inc;
    } t_cut;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [SLOT_BITS-1:0] slot);
        slot_addr = ADDR_BITS'(slot);
    endfunction

    // Emission order of the cut edges for each case.
    function automatic t_cut cut_of(input t_mode mode, input logic [2:0] step);
        t_cut c;
        c = '{lo: 2'd0, hi: 2'd1, tri_inc: 1'b0};
        case (mode)
            MODE_LOW: begin
                c.hi = (step == 3'd0) ? 2'd1 : (step == 3'd1) ? 2'd2 : 2'd3;
            end
            MODE_HIGH: begin
                c.hi = 2'd3;
                c.lo = (step == 3'd0) ? 2'd0 : (step == 3'd1) ? 2'd1 : 2'd2;
            end
            MODE_QUAD: begin
                case (step)
                    3'd0:    c = '{lo: 2'd0, hi: 2'd2, tri_inc: 1'b0};
                    3'd1:    c = '{lo: 2'd0, hi: 2'd3, tri_inc: 1'b0};
                    3'd2:    c = '{lo: 2'd1, hi: 2'd2, tri_inc: 1'b0};
                    3'd3:    c = '{lo: 2'd1, hi: 2'd3, tri_inc: 1'b1};
                    3'd4:    c = '{lo: 2'd1, hi: 2'd2, tri_inc: 1'b1};
                    default: c = '{lo: 2'd0, hi: 2'd3, tri_inc: 1'b1};
                endcase
            end
            default: c = '{lo: 2'd0, hi: 2'd1, tri_inc: 1'b0};
        endcase
        cut_of = c;
    endfunction

endpackage

>>> rtl/core/tie_vtx_mem.sv
// Vertex table: one write port and one registered read port.
// Depends on tie_pkg.
module tie_vtx_mem import tie_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  t_vtx                 i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output t_vtx                 o_rdata
);

    t_vtx r_mem [VERTEX_DEPTH];
    t_vtx r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tie_div.sv
// Restoring divider, one quotient bit per cycle, shared by all cut interpolations.
// Depends on tie_pkg.
module tie_div import tie_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_BITS-1:0]   i_numer,
    input  logic [DENS_BITS:0]    i_den2,
    output t_div_stat             o_stat,
    output logic [COORD_BITS-1:0] o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [REM_BITS-1:0]   r_rem;
    logic [COORD_BITS-1:0] r_nlo;
    logic [COORD_BITS-1:0] r_quo;
    logic [DENS_BITS:0]    r_den2;
    logic [REM_BITS-1:0]   w_trial;
    logic                  w_ge;

    // Shift in the next dividend bit and test against the divisor.
    assign w_trial = {r_rem[REM_BITS-2:0], r_nlo[COORD_BITS-1]};
    assign w_ge    = w_trial >= REM_BITS'(r_den2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= REM_BITS'(i_numer >> COORD_BITS);
                r_nlo  <= i_numer[COORD_BITS-1:0];
                r_den2 <= i_den2;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_trial - REM_BITS'(r_den2)) : w_trial;
                r_nlo <= {r_nlo[COORD_BITS-2:0], 1'b0};
                r_quo <= {r_quo[COORD_BITS-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_BITS'(COORD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_quo;

endmodule

>>> rtl/core/tetrahedral_isosurface_extractor_top.sv
// Top level of the tetrahedral isosurface extractor: sequencer, corner sort, cut arithmetic.
// Depends on tie_pkg, tie_vtx_mem and tie_div.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_stall   | i_req_type, i_vertex_slot, i_load_*, i_corner_*
//  output  | out       | o_out_valid / i_out_stall | o_out_x/y/z, o_triangle_number, o_last_of_run
//  config  | in        | i_cfg_we                  | i_cfg_wdata (iso level)
//
// Load, restart and unused items are handled in the idle state. A tetrahedron goes through
// corner reads, sort and checks, then through multiply and divide per emitted vertex (0, 3 or 6):
// each of the three axes needs a multiply step and a pass through the serial divider.
// Reset is synchronous and active low; it clears the triangle counter and sets the level
// to one half. Stalls on the output only hold the sequencer; the vertex table needs no clear.
module tetrahedral_isosurface_extractor_top import tie_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DENS_BITS-1:0]  i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [SLOT_BITS-1:0]  i_vertex_slot,
    input  logic [COORD_BITS-1:0] i_load_x,
    input  logic [COORD_BITS-1:0] i_load_y,
    input  logic [COORD_BITS-1:0] i_load_z,
    input  logic [DENS_BITS-1:0]  i_load_density,
    input  logic [SLOT_BITS-1:0]  i_corner_a,
    input  logic [SLOT_BITS-1:0]  i_corner_b,
    input  logic [SLOT_BITS-1:0]  i_corner_c,
    input  logic [SLOT_BITS-1:0]  i_corner_d,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [COORD_BITS-1:0] o_out_z,
    output logic [CNT_BITS-1:0]   o_triangle_number,
    output logic                  o_last_of_run
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_SORT,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                r_state;
    logic [DENS_BITS-1:0]  r_iso;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [SLOT_BITS-1:0]  r_corner [4];
    logic [1:0]            r_idx;
    logic                  r_cap_vld;
    logic [1:0]            r_cap_idx;
    t_vtx                  r_v  [4];
    t_vtx                  r_sv [4];
    t_mode                 r_mode;
    logic [2:0]            r_step;
    logic [1:0]            r_ax;
    logic                  r_div_go;
    logic [NUM_BITS-1:0]   r_numer;
    logic [DENS_BITS:0]    r_den2;
    logic [COORD_BITS-1:0] r_plo;
    logic                  r_up;
    logic                  r_ov;
    logic [COORD_BITS-1:0] r_ox;
    logic [COORD_BITS-1:0] r_oy;
    logic [COORD_BITS-1:0] r_oz;
    logic [CNT_BITS-1:0]   r_otri;
    logic                  r_olast;

    logic                  w_accept;
    logic                  w_mem_we;
    t_vtx                  w_rdata;
    t_vtx                  w_sorted [4];
    t_cut                  w_cut;
    t_vtx                  w_lo;
    t_vtx                  w_hi;
    logic [DENS_BITS-1:0]  w_num;
    logic [DENS_BITS-1:0]  w_den;
    logic [COORD_BITS-1:0] w_plo;
    logic [COORD_BITS-1:0] w_phi;
    logic                  w_up;
    logic [COORD_BITS-1:0] w_mag;
    logic [COORD_BITS+DENS_BITS-1:0] w_prod;
    logic [COORD_BITS-1:0] w_quot;
    logic [COORD_BITS-1:0] w_res;
    logic                  w_skip;
    logic                  w_last_cut;
    t_div_stat             w_div;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_mem_we   = w_accept && (i_req_type == REQ_LOAD);
    assign o_in_stall = (r_state != ST_IDLE);

    // Vertex table.
    tie_vtx_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (slot_addr(i_vertex_slot)),
        .i_wdata ('{x: i_load_x, y: i_load_y, z: i_load_z, d: i_load_density}),
        .i_re    (r_state == ST_READ),
        .i_raddr (slot_addr(r_corner[r_idx])),
        .o_rdata (w_rdata)
    );

    // Shared divider.
    tie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_numer (r_numer),
        .i_den2  (r_den2),
        .o_stat  (w_div),
        .o_quot  (w_quot)
    );

    // Sort corners by rising density; ties break by corner order.
    always_comb begin
        logic [1:0] rank [4];
        for (int i = 0; i < 4; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < 4; j++) begin
                if ((r_v[j].d < r_v[i].d) || ((r_v[j].d == r_v[i].d) && (j < i))) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
        end
        for (int r = 0; r < 4; r++) begin
            w_sorted[r] = r_v[0];
            for (int i = 0; i < 4; i++) begin
                if (rank[i] == 2'(r)) begin
                    w_sorted[r] = r_v[i];
                end
            end
        end
    end

    // Degenerate tetrahedra and levels outside or on a corner emit nothing.
    assign w_skip = (r_sv[0].d == r_sv[1].d) || (r_sv[1].d == r_sv[2].d) ||
                    (r_sv[2].d == r_sv[3].d) || (r_iso <= r_sv[0].d) ||
                    (r_iso >= r_sv[3].d) || (r_iso == r_sv[1].d) || (r_iso == r_sv[2].d);

    // Operands of the current cut and axis.
    assign w_cut = cut_of(r_mode, r_step);
    assign w_lo  = r_sv[w_cut.lo];
    assign w_hi  = r_sv[w_cut.hi];
    assign w_num = r_iso - w_lo.d;
    assign w_den = w_hi.d - w_lo.d;

    always_comb begin
        case (r_ax)
            2'd0: begin
                w_plo = w_lo.x;
                w_phi = w_hi.x;
            end
            2'd1: begin
                w_plo = w_lo.y;
                w_phi = w_hi.y;
            end
            default: begin
                w_plo = w_lo.z;
                w_phi = w_hi.z;
            end
        endcase
    end

    assign w_up   = (w_phi >= w_plo);
    assign w_mag  = w_up ? (w_phi - w_plo) : (w_plo - w_phi);
    assign w_prod = (COORD_BITS+DENS_BITS)'(w_mag) * (COORD_BITS+DENS_BITS)'(w_num);
    assign w_res  = r_up ? (r_plo + w_quot) : (r_plo - w_quot);
    assign w_last_cut = (r_mode == MODE_QUAD) ? (r_step == 3'd5) : (r_step == 3'd2);

    // Sequencer, configuration and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_iso     <= DENS_BITS'(32768);
            r_cnt     <= '0;
            r_cap_vld <= 1'b0;
            r_div_go  <= 1'b0;
            r_ov      <= 1'b0;
            r_idx     <= '0;
            r_step    <= '0;
            r_ax      <= '0;
        end else begin
            r_div_go  <= 1'b0;
            r_cap_vld <= (r_state == ST_READ);
            r_cap_idx <= r_idx;
            if (r_cap_vld) begin
                r_v[r_cap_idx] <= w_rdata;
            end
            if (i_cfg_we) begin
                r_iso <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_req_type)
                            REQ_TETRA: begin
                                r_corner[0] <= i_corner_a;
                                r_corner[1] <= i_corner_b;
                                r_corner[2] <= i_corner_c;
                                r_corner[3] <= i_corner_d;
                                r_idx       <= '0;
                                r_state     <= ST_READ;
                            end
                            REQ_RESTART: r_cnt <= '0;
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: r_state <= ST_SORT;
                ST_SORT: begin
                    for (int r = 0; r < 4; r++) begin
                        r_sv[r] <= w_sorted[r];
                    end
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_step <= '0;
                    r_ax   <= '0;
                    if (r_iso < r_sv[1].d) begin
                        r_mode <= MODE_LOW;
                    end else if (r_iso > r_sv[2].d) begin
                        r_mode <= MODE_HIGH;
                    end else begin
                        r_mode <= MODE_QUAD;
                    end
                    r_state <= w_skip ? ST_IDLE : ST_MUL;
                end
                ST_MUL: begin
                    r_numer  <= {w_prod, 1'b0} + NUM_BITS'(w_den);
                    r_den2   <= {w_den, 1'b0};
                    r_plo    <= w_plo;
                    r_up     <= w_up;
                    r_div_go <= 1'b1;
                    r_state  <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        case (r_ax)
                            2'd0:    r_ox <= w_res;
                            2'd1:    r_oy <= w_res;
                            default: r_oz <= w_res;
                        endcase
                        if (r_ax == 2'd2) begin
                            r_otri  <= r_cnt + CNT_BITS'(w_cut.tri_inc);
                            r_olast <= w_last_cut;
                            r_ov    <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_ov <= 1'b0;
                        r_ax <= '0;
                        if (r_olast) begin
                            r_cnt   <= r_cnt + ((r_mode == MODE_QUAD) ? CNT_BITS'(2)
                                                                      : CNT_BITS'(1));
                            r_state <= ST_IDLE;
                        end else begin
                            r_step  <= r_step + 3'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_ov;
    assign o_out_x           = r_ox;
    assign o_out_y           = r_oy;
    assign o_out_z           = r_oz;
    assign o_triangle_number = r_otri;
    assign o_last_of_run     = r_olast;

    // The final vertex of a tetrahedron returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run && !i_out_stall) |=> (r_state == ST_IDLE))
        else $error("sequencer not idle after last vertex");

    // A tetrahedron item blocks further input on the next cycle.
    a_tetra_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_TETRA)) |=> o_in_stall)
        else $error("input not stalled after tetrahedron transfer");

    // The divider only runs while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_state == ST_DIV))
        else $error("divider busy outside divide state");

    // A result is only shown in the output state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == ST_OUT))
        else $error("output valid outside output state");

endmodule
